FILE: rtl/core/sfa_pkg.sv
// Package: shared constants and types of the segregated free-list allocator.
package sfa_pkg;

  localparam int HeapWords = 65536;
  localparam int MemWords  = (HeapWords < 65536) ? HeapWords : 65536;
  localparam int WordAw    = (MemWords > 1) ? $clog2(MemWords) : 1;
  localparam logic [18:0] MemBytes = 19'(MemWords * 4);
  localparam int NumLists  = 14;
  localparam logic [3:0] LargeList = 4'd13;
  localparam logic [17:0] HdrBytes = 18'd12;
  localparam logic [17:0] HeapStartReset = 18'd1024;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_FREE    = 3'd1,
    ACT_RETAIN  = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_TAG     = 3'd4
  } action_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_OOM    = 2'd1;
  localparam logic [1:0] ST_IGNORE = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SMALL_RD,
    S_SMALL_WAIT,
    S_LARGE_RD,
    S_LARGE_WAIT,
    S_LARGE_LINK,
    S_LARGE_LWAIT,
    S_BUMP,
    S_WR_TAG,
    S_WR_CNT,
    S_CNT_RD,
    S_CNT_WAIT,
    S_FREE_RD,
    S_FREE_WAIT,
    S_FREE_WR,
    S_TAG_RD,
    S_TAG_WAIT,
    S_OUT
  } state_t;

  // class of a byte size: 0..12 small, 13 large
  function automatic logic [3:0] class_of(input logic [31:0] size);
    logic [31:0] v;
    logic [3:0] c;
    begin
      v = (size[31] || size < 32'd16) ? 32'd15 : size - 32'd1;
      c = LargeList;
      for (int i = 12; i >= 0; i--) begin
        if (v < (32'd1 << (i + 4))) c = 4'(i);
      end
      class_of = c;
    end
  endfunction

endpackage

FILE: rtl/core/sfa_ram.sv
// Generic single-port RAM with registered read.
module sfa_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/segregated_freelist_allocator_top.sv
// Top level: segregated free-list heap allocator over a word RAM.
// One word at a time: each action runs a sequencer around a single-port heap
// RAM (one access per cycle, registered read). A small alloc pops its class
// list, else takes from the bump pointer; a large alloc walks the large list
// first fit, else takes from the bump pointer; either reports out of memory
// when the bump pointer would pass the heap end. Free pushes the block on its
// class list; retain and release step the count, release freeing at zero;
// a tag query reads the tag; a null pointer or unknown action is ignored.
// The result sits in an output register, so the next word is accepted while
// it waits; that word then holds in its last cycle until the register frees.
module segregated_freelist_allocator_top
  import sfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [17:0]  cfg_wdata,        // heap_start
  input  logic         s_tvalid,
  output logic         s_tready,
  // [2:0] action, [21:3] request_bytes, [53:22] object_kind, [71:54] payload_address
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [17:0] result_address, [49:18] tag_read, [51:50] status, [52] block_freed
  output logic [55:0]  m_tdata
);

  state_t state, state_next;

  logic [2:0]  action;
  logic [18:0] req;
  logic [31:0] kind;
  logic [17:0] ptr;
  logic [17:0] heads [NumLists];
  logic [18:0] bump;
  logic [17:0] curr, prev, blk;
  logic [31:0] need;
  logic [3:0]  cls;
  logic [16:0] walk;
  logic [17:0] res;
  logic [31:0] tag;
  logic [1:0]  status;
  logic        freed;
  logic        out_free;

  logic        ram_we;
  logic [17:0] ram_baddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic        ram_in;
  logic        ram_in_q;

  assign ram_in = ({2'b0, ram_baddr[17:2]} < 18'(MemWords));

  sfa_ram #(.Width(32), .Depth(MemWords)) u_heap (
    .clk   (clk),
    .we    (ram_we & ram_in),
    .addr  (ram_baddr[WordAw+1:2]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic [31:0] rd;
  assign rd = ram_in_q ? ram_rdata : 32'd0;
  always_ff @(posedge clk) ram_in_q <= ram_in;

  logic [31:0] size_tot;
  assign size_tot = 32'((20'(req) + 20'd3) & 20'hFFFFC) + 32'd12;
  logic [3:0] cls_req;
  assign cls_req = class_of(size_tot);
  logic [3:0] cls_rd;
  assign cls_rd = class_of(rd);
  logic [19:0] nb;
  assign nb = 20'(bump) + 20'(need[19:0]);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid && s_tready) state_next = S_DECODE;
      S_DECODE: begin
        unique case (action)
          ACT_ALLOC: state_next = (cls_req == LargeList)
                                 ? ((heads[LargeList] == 18'd0) ? S_BUMP : S_LARGE_RD)
                                 : ((heads[cls_req] == 18'd0) ? S_BUMP : S_SMALL_RD);
          ACT_FREE: state_next = (ptr == 18'd0) ? S_OUT : S_FREE_RD;
          ACT_RETAIN, ACT_RELEASE: state_next = (ptr == 18'd0) ? S_OUT : S_CNT_RD;
          ACT_TAG: state_next = (ptr == 18'd0) ? S_OUT : S_TAG_RD;
          default: state_next = S_OUT;
        endcase
      end
      S_SMALL_RD: state_next = S_SMALL_WAIT;
      S_SMALL_WAIT: state_next = S_WR_TAG;
      S_LARGE_RD: state_next = S_LARGE_WAIT;
      S_LARGE_WAIT: state_next = S_LARGE_LINK;
      S_LARGE_LINK: state_next = S_LARGE_LWAIT;
      S_LARGE_LWAIT: begin
        if (blk != 18'd0) state_next = S_WR_TAG;
        else if (rd[17:0] == 18'd0 || walk == 17'(MemWords - 1)) state_next = S_BUMP;
        else state_next = S_LARGE_RD;
      end
      S_BUMP: state_next = (nb > 20'(MemBytes)) ? S_OUT : S_WR_TAG;
      S_WR_TAG: state_next = S_WR_CNT;
      S_WR_CNT: state_next = S_OUT;
      S_CNT_RD: state_next = S_CNT_WAIT;
      S_CNT_WAIT: state_next = (action == ACT_RELEASE && rd == 32'd1) ? S_FREE_RD : S_OUT;
      S_FREE_RD: state_next = S_FREE_WAIT;
      S_FREE_WAIT: state_next = (rd == 32'd0) ? S_OUT : S_FREE_WR;
      S_FREE_WR: state_next = S_OUT;
      S_TAG_RD: state_next = S_TAG_WAIT;
      S_TAG_WAIT: state_next = S_OUT;
      S_OUT: state_next = out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_baddr = 18'd0;
    ram_wdata = 32'd0;
    unique case (state)
      S_SMALL_RD: ram_baddr = blk + 18'd4;
      S_LARGE_RD: ram_baddr = curr;
      S_LARGE_LINK: ram_baddr = curr + 18'd4;
      S_LARGE_LWAIT: begin
        if (blk != 18'd0 && prev != 18'd0) begin
          ram_we = 1'b1;
          ram_baddr = prev + 18'd4;
          ram_wdata = rd;
        end
      end
      S_BUMP: begin
        ram_we = !(nb > 20'(MemBytes));
        ram_baddr = bump[17:0];
        ram_wdata = need;
      end
      S_WR_TAG: begin
        ram_we = 1'b1;
        ram_baddr = blk + 18'd4;
        ram_wdata = kind;
      end
      S_WR_CNT: begin
        ram_we = 1'b1;
        ram_baddr = blk + 18'd8;
        ram_wdata = 32'd1;
      end
      S_CNT_RD: ram_baddr = ptr - 18'd4;
      S_CNT_WAIT: begin
        ram_we = 1'b1;
        ram_baddr = ptr - 18'd4;
        ram_wdata = (action == ACT_RETAIN) ? rd + 32'd1 : rd - 32'd1;
      end
      S_FREE_RD: ram_baddr = ptr - HdrBytes;
      S_FREE_WR: begin
        ram_we = 1'b1;
        ram_baddr = ptr - HdrBytes + 18'd4;
        ram_wdata = {14'd0, heads[cls]};
      end
      S_TAG_RD: ram_baddr = ptr - 18'd8;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      bump <= 19'(HeapStartReset);
      for (int i = 0; i < NumLists; i++) heads[i] <= 18'd0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_we) bump <= {1'b0, cfg_wdata[17:2], 2'b00};
      unique case (state)
        S_IDLE: begin
          action <= s_tdata[2:0];
          req <= s_tdata[21:3];
          kind <= s_tdata[53:22];
          ptr <= s_tdata[71:54];
          res <= 18'd0;
          tag <= 32'd0;
          status <= ST_DONE;
          freed <= 1'b0;
        end
        S_DECODE: begin
          prev <= 18'd0;
          walk <= 17'd0;
          if (action == ACT_ALLOC) begin
            if (cls_req == LargeList) begin
              need <= size_tot;
              curr <= heads[LargeList];
              blk <= 18'd0;
            end else begin
              need <= 32'd1 << (5'(cls_req) + 5'd4);
              blk <= heads[cls_req];
            end
            cls <= cls_req;
          end else begin
            blk <= 18'd0;
            if (ptr == 18'd0 || action > ACT_TAG) status <= ST_IGNORE;
          end
        end
        S_SMALL_WAIT: heads[cls] <= rd[17:0];
        S_LARGE_WAIT: if (!rd[31] && rd >= need) blk <= curr;
        S_LARGE_LWAIT: begin
          if (blk != 18'd0) begin
            if (prev == 18'd0) heads[LargeList] <= rd[17:0];
          end else begin
            prev <= curr;
            curr <= rd[17:0];
            walk <= walk + 17'd1;
          end
        end
        S_BUMP: begin
          if (nb > 20'(MemBytes)) status <= ST_OOM;
          else begin
            blk <= bump[17:0];
            bump <= nb[18:0];
          end
        end
        S_WR_CNT: res <= blk + HdrBytes;
        S_FREE_WAIT: begin
          if (rd == 32'd0) status <= ST_IGNORE;
          else cls <= cls_rd;
        end
        S_FREE_WR: begin
          heads[cls] <= ptr - HdrBytes;
          freed <= 1'b1;
        end
        S_TAG_WAIT: tag <= rd;
        S_OUT: if (out_free) m_tdata <= {3'b0, freed, status, tag, res};
        default: ;
      endcase
    end
  end

endmodule

FILE: verif/sfa_checker.sv
`timescale 1ns / 100ps
// Checker: watches the allocator's channels, predicts each result word and compares.
module sfa_checker
  import sfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [17:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          errors,
  output int          waiting
);

  typedef struct packed {
    logic [17:0] addr;
    logic [31:0] tag;
    logic [1:0]  status;
    logic        freed;
  } outcome_t;

  localparam logic [31:0] AddrMask = 32'h3FFFF;

  outcome_t    outcome_q[$];
  logic [31:0] heap_mem[int unsigned];
  logic [31:0] list_head[NumLists];
  logic [31:0] bump;

  function automatic logic [31:0] peek(input logic [31:0] a);
    int unsigned w;
    w = (a & AddrMask) >> 2;
    if (w < MemWords && heap_mem.exists(w)) return heap_mem[w];
    return 32'd0;
  endfunction

  function automatic void poke(input logic [31:0] a, input logic [31:0] v);
    int unsigned w;
    w = (a & AddrMask) >> 2;
    if (w < MemWords) heap_mem[w] = v;
  endfunction

  // 0..12 small classes, 13 the large list
  function automatic int unsigned bucket_of(input logic [31:0] sz);
    if (sz[31]) return 0;
    for (int c = 0; c < 13; c++) begin
      if (sz <= (32'd16 << c)) return c;
    end
    return 13;
  endfunction

  function automatic logic [1:0] push_free(input logic [31:0] ptr, output logic freed);
    logic [31:0] blk;
    logic [31:0] sz;
    int unsigned cls;
    freed = 1'b0;
    if (ptr == 0) return ST_IGNORE;
    blk = (ptr - 32'd12) & AddrMask;
    sz = peek(blk);
    if (sz == 0) return ST_IGNORE;
    cls = bucket_of(sz);
    poke(blk + 32'd4, list_head[cls]);
    list_head[cls] = blk;
    freed = 1'b1;
    return ST_DONE;
  endfunction

  function automatic outcome_t predict(input logic [71:0] w);
    logic [2:0]  act;
    logic [31:0] req, kind, ptr, size, need, blk, curr, prev, nxt, bs, a, old;
    logic        f;
    int unsigned cls;
    outcome_t    o;
    act = w[2:0];
    req = {13'd0, w[21:3]};
    kind = w[53:22];
    ptr = {14'd0, w[71:54]};
    o = '0;
    blk = 0;
    need = 0;
    case (act)
      ACT_ALLOC: begin
        size = ((req + 32'd3) & ~32'd3) + 32'd12;
        cls = bucket_of(size);
        if (cls == 13) begin
          need = size;
          curr = list_head[LargeList];
          prev = 0;
          for (int n = 0; n < MemWords && curr != 0; n++) begin
            bs = peek(curr);
            if (!bs[31] && bs >= size) begin
              nxt = peek(curr + 32'd4);
              if (prev == 0) list_head[LargeList] = nxt & AddrMask;
              else poke(prev + 32'd4, nxt);
              blk = curr;
              break;
            end
            prev = curr;
            curr = peek(curr + 32'd4) & AddrMask;
          end
        end else begin
          need = 32'd16 << cls;
          blk = list_head[cls];
          if (blk != 0) list_head[cls] = peek(blk + 32'd4) & AddrMask;
        end
        if (blk == 0) begin
          if (bump + need > {13'd0, MemBytes}) begin
            o.status = ST_OOM;
          end else begin
            blk = bump;
            bump = bump + need;
            poke(blk, need);
          end
        end
        if (o.status == ST_DONE) begin
          poke(blk + 32'd4, kind);
          poke(blk + 32'd8, 32'd1);
          o.addr = 18'(blk + 32'd12);
        end
      end
      ACT_FREE: begin
        o.status = push_free(ptr, f);
        o.freed = f;
      end
      ACT_RETAIN: begin
        if (ptr == 0) begin
          o.status = ST_IGNORE;
        end else begin
          a = (ptr - 32'd4) & AddrMask;
          poke(a, peek(a) + 32'd1);
        end
      end
      ACT_RELEASE: begin
        if (ptr == 0) begin
          o.status = ST_IGNORE;
        end else begin
          a = (ptr - 32'd4) & AddrMask;
          old = peek(a);
          poke(a, old - 32'd1);
          if (old == 32'd1) begin
            o.status = push_free(ptr, f);
            o.freed = f;
          end
        end
      end
      ACT_TAG: begin
        if (ptr == 0) o.status = ST_IGNORE;
        else o.tag = peek((ptr - 32'd8) & AddrMask);
      end
      default: o.status = ST_IGNORE;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst) begin
      heap_mem.delete();
      outcome_q.delete();
      foreach (list_head[i]) list_head[i] = 32'd0;
      bump = {14'd0, HeapStartReset};
      errors = 0;
    end else begin
      if (cfg_we) bump = {14'd0, cfg_wdata[17:2], 2'b00};
      if (s_tvalid && s_tready) outcome_q.push_back(predict(s_tdata));
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (m_tdata[17:0] !== want.addr) begin
            $error("result_address: expected %h, got %h", want.addr, m_tdata[17:0]);
            errors++;
          end
          if (m_tdata[49:18] !== want.tag) begin
            $error("tag_read: expected %h, got %h", want.tag, m_tdata[49:18]);
            errors++;
          end
          if (m_tdata[51:50] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[51:50]);
            errors++;
          end
          if (m_tdata[52] !== want.freed) begin
            $error("block_freed: expected %0d, got %0d", want.freed, m_tdata[52]);
            errors++;
          end
        end
      end
    end
    waiting = outcome_q.size();
  end

endmodule

FILE: verif/segregated_freelist_allocator_top_test.sv
`timescale 1ns / 100ps
// Testbench top: drives allocator traffic and idling, then reports the verdict.
module segregated_freelist_allocator_top_test;
  import sfa_pkg::*;

  localparam logic [2:0] ACT_BAD = 3'd5;

  typedef struct packed {
    logic [2:0]  act;
    logic [18:0] req;
  } sent_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [17:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  int          errors;
  int          waiting;

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  sent_t       sent_q[$];
  logic [17:0] live_ptr[$];
  int unsigned live_refs[$];
  logic [17:0] last_res;
  int unsigned high_water = 0;
  int unsigned n_act[8];
  int unsigned n_oom = 0;
  int unsigned n_freed = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  segregated_freelist_allocator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sfa_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .waiting  (waiting)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // track live blocks and the highest byte handed out
  always @(posedge clk) begin : watch
    sent_t       s;
    int unsigned sz, nd, top_end;
    if (s_tvalid && s_tready) sent_q.push_back({s_tdata[2:0], s_tdata[21:3]});
    if (m_tvalid && m_tready && sent_q.size() != 0) begin
      s = sent_q.pop_front();
      if (m_tdata[51:50] == ST_OOM) n_oom++;
      if (m_tdata[52]) n_freed++;
      if (s.act == ACT_ALLOC && m_tdata[51:50] == ST_DONE) begin
        last_res = m_tdata[17:0];
        live_ptr.push_back(m_tdata[17:0]);
        live_refs.push_back(1);
        sz = ((s.req + 3) & ~32'd3) + 12;
        if (sz > 65536) begin
          nd = sz;
        end else begin
          nd = 16;
          while (nd < sz) nd = nd << 1;
        end
        top_end = (m_tdata[17:0] & ~18'd3) - 12 + nd;
        if (top_end > high_water) high_water = top_end;
      end
    end
  end

  task automatic send_word(input logic [2:0] act, input logic [18:0] req,
                           input logic [31:0] kind, input logic [17:0] ptr);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ptr, kind, req, act};
    n_act[act]++;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sent_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic step(input logic [2:0] act, input logic [18:0] req,
                      input logic [31:0] kind, input logic [17:0] ptr);
    send_word(act, req, kind, ptr);
    drain;
  endtask

  task automatic forget(input logic [17:0] p);
    for (int i = 0; i < live_ptr.size(); i++) begin
      if (live_ptr[i] == p) begin
        live_ptr.delete(i);
        live_refs.delete(i);
        break;
      end
    end
  endtask

  // set a new heap start once drained; fresh_start gives one above all used so far, low bits set to be dropped
  task automatic write_heap_start(input logic [17:0] v);
    drain;
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [17:0] fresh_start();
    return (high_water + 3 > 262140) ? 18'd262140 : 18'(high_water + 3);
  endfunction

  task automatic random_word(input int unsigned req_cap);
    logic [2:0]  act;
    logic [18:0] req;
    logic [17:0] ptr;
    int unsigned r, i;
    r = $urandom_range(99);
    req = 19'($urandom);
    ptr = 18'($urandom);
    if (r < 38) act = ACT_ALLOC;
    else if (r < 52) act = ACT_FREE;
    else if (r < 66) act = ACT_RETAIN;
    else if (r < 84) act = ACT_RELEASE;
    else if (r < 95) act = ACT_TAG;
    else act = 3'(ACT_BAD + $urandom_range(2));
    if (act == ACT_ALLOC) begin
      r = $urandom_range(99);
      if (r < 70) req = 19'($urandom_range(64));
      else if (r < 90) req = 19'($urandom_range(1024));
      else if (r < 97) req = 19'($urandom_range(8192));
      else req = 19'($urandom_range(262144));
      if (req > req_cap) req = 19'($urandom_range(req_cap));
    end else if (act < ACT_BAD) begin
      if (live_ptr.size() != 0 && $urandom_range(19) != 0) begin
        i = $urandom_range(live_ptr.size() - 1);
        ptr = {live_ptr[i][17:2], 2'($urandom_range(3))};
        if (act == ACT_FREE) begin
          live_ptr.delete(i);
          live_refs.delete(i);
        end else if (act == ACT_RETAIN) begin
          live_refs[i]++;
        end else if (act == ACT_RELEASE) begin
          live_refs[i]--;
          if (live_refs[i] == 0) begin
            live_ptr.delete(i);
            live_refs.delete(i);
          end
        end
      end else begin
        ptr = '0;
      end
    end
    send_word(act, req, $urandom, ptr);
  endtask

  task automatic run_random(input int n, input int unsigned req_cap);
    repeat (n) random_word(req_cap);
  endtask

  initial begin : stim
    logic [17:0] p0, p1, p2, q, a, b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset heap start
    step(ACT_ALLOC, 19'd0, 32'h7FFFFFFF, '0);       p0 = last_res;
    step(ACT_ALLOC, 19'd16000, 32'h80000000, '0);   p1 = last_res;
    step(ACT_ALLOC, 19'd5, 32'h0, '0);              p2 = last_res;
    step(ACT_TAG, '0, '0, p0);
    step(ACT_RETAIN, '0, '0, p0);
    step(ACT_RELEASE, '0, '0, p0);
    step(ACT_RELEASE, '0, '0, p0);                  // count hits zero, block freed
    forget(p0);
    step(ACT_ALLOC, 19'd1, 32'd12345, '0);          // reuses the freed block
    step(ACT_FREE, '0, '0, p1);
    forget(p1);
    step(ACT_FREE, '0, '0, p2 + 18'd4);             // zero tag read as size: empty header
    step(ACT_ALLOC, 19'd7, 32'hFFFFFFFB, '0);       q = last_res;
    forget(q);
    step(ACT_FREE, '0, '0, q + 18'd4);              // negative size goes to class 0
    step(ACT_ALLOC, 19'd0, 32'h5A5A5A5A, '0);
    step(ACT_FREE, '0, '0, '0);
    step(ACT_RETAIN, '0, '0, '0);
    step(ACT_RELEASE, '0, '0, '0);
    step(ACT_TAG, '0, '0, '0);
    step(ACT_ALLOC, 19'd262144, 32'h1, '0);          // out of memory
    for (int k = 0; k < 3; k++) step(3'(ACT_BAD + k), 19'($urandom), $urandom, 18'($urandom));

    // low extreme: bump from 0, kept below the earlier region
    write_heap_start(18'd0);
    run_random(30, 20);

    // large list: first fit, unlink at head and behind a block
    write_heap_start(fresh_start());
    step(ACT_ALLOC, 19'd65528, 32'hA, '0);          a = last_res;
    step(ACT_ALLOC, 19'd65588, 32'hB, '0);          b = last_res;
    step(ACT_FREE, '0, '0, b);
    step(ACT_FREE, '0, '0, a);
    forget(a);
    forget(b);
    step(ACT_ALLOC, 19'd65548, 32'hC, '0);
    step(ACT_ALLOC, 19'd65528, 32'hD, '0);
    step(ACT_ALLOC, 19'd200000, 32'hE, '0);

    write_heap_start(fresh_start());
    hold_req = 1'b1;
    run_random(400, 262144);
    src_idle_pct = 60;
    run_random(400, 262144);
    drain;
    write_heap_start(fresh_start());
    src_idle_pct = 0;
    snk_idle_pct = 60;
    hold_req = 1'b1;
    run_random(400, 262144);
    src_idle_pct = 13;
    snk_idle_pct = 13;
    run_random(300, 262144);
    write_heap_start(18'd262140);                    // high extreme: bump always full
    run_random(100, 262144);

    drain;
    snk_idle_pct = 0;
    repeat (20) @(posedge clk);
    $display("covered %0d alloc, %0d free, %0d retain, %0d release, %0d tag words",
             n_act[ACT_ALLOC], n_act[ACT_FREE], n_act[ACT_RETAIN], n_act[ACT_RELEASE],
             n_act[ACT_TAG]);
    $display("  plus %0d unknown; %0d out of memory, %0d blocks returned to lists",
             n_act[5] + n_act[6] + n_act[7], n_oom, n_freed);
    if (errors == 0 && waiting == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sfa_pkg.sv
rtl/core/sfa_ram.sv
rtl/core/segregated_freelist_allocator_top.sv
verif/sfa_checker.sv
verif/segregated_freelist_allocator_top_test.sv
